@@ src/cfd_pkg.sv @@
// Shared constants, codes and the front-to-back operation type of the COBS frame decoder.
package cfd_pkg;

   // Frame limits.
   localparam int MAX_PAYLOAD = 1024;
   localparam int MAX_WIRE    = 1048;
   localparam int HDR_LEN     = 16;

   // Derived widths.
   localparam int DEC_W  = $clog2(HDR_LEN + MAX_PAYLOAD + 1);
   localparam int WIRE_W = $clog2(MAX_WIRE + 1);
   localparam int HDR_AW = $clog2(HDR_LEN);
   localparam int IDX_W  = 10;
   localparam int LEN_W  = 16;

   // Queue between the decode front and the frame back.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   // Code byte that opens a group without a trailing implied zero.
   localparam logic [7:0] CODE_LONG_GROUP = 8'hff;

   // Header magic, one byte per position.
   localparam logic [7:0] MAGIC_0 = 8'h4e;
   localparam logic [7:0] MAGIC_1 = 8'h34;
   localparam logic [7:0] MAGIC_2 = 8'h55;
   localparam logic [7:0] MAGIC_3 = 8'h31;

   typedef enum logic [2:0] {
      ERR_NONE,
      ERR_WIRE_LONG,
      ERR_TRUNCATED,
      ERR_DECODED_LONG,
      ERR_SHORT,
      ERR_MAGIC,
      ERR_SIZE,
      ERR_MISMATCH
   } err_type;

   typedef enum logic {
      KIND_PAYLOAD,
      KIND_SUMMARY
   } kind_type;

   // One decoded byte or one end of frame, as handed from front to back.
   typedef struct packed {
      kind_type           kind;
      logic [7:0]         data;
      err_type            err;
      logic [DEC_W-1:0]   count;
   } op_type;

endpackage

@@ src/cfd_front.sv @@
// Decode front: accepts wire bytes, undoes the stuffing and queues decoded bytes and frame ends.
module cfd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [7:0]       req_wire_byte,
   output logic             req_stall,
   input  logic             fifo_full,
   output logic             push_valid,
   output cfd_pkg::op_type  push_op
);
   import cfd_pkg::*;

   logic [7:0]        group_left_ff, group_left_in;
   logic              zero_pending_ff, zero_pending_in;
   logic              long_group_ff, long_group_in;
   logic [WIRE_W-1:0] wire_count_ff, wire_count_in;
   logic [DEC_W-1:0]  dec_count_ff, dec_count_in;
   err_type           err_ff, err_in;
   logic              accept;
   logic              append_req;
   logic [7:0]        append_val;

   assign req_stall = fifo_full;
   assign accept    = req_valid && !fifo_full;

   // Next state of the group counter, the counts and the error latch.
   always_comb begin
      group_left_in   = group_left_ff;
      zero_pending_in = zero_pending_ff;
      long_group_in   = long_group_ff;
      wire_count_in   = wire_count_ff;
      dec_count_in    = dec_count_ff;
      err_in          = err_ff;
      append_req      = 1'b0;
      append_val      = 8'd0;
      push_valid      = 1'b0;
      push_op.kind    = KIND_PAYLOAD;
      push_op.data    = 8'd0;
      push_op.err     = ERR_NONE;
      push_op.count   = dec_count_ff;

      if (accept) begin
         if (req_wire_byte == 8'd0) begin
            // Delimiter: a repeated one with nothing since gives no beat.
            if (wire_count_ff != '0 || err_ff != ERR_NONE) begin
               push_valid   = 1'b1;
               push_op.kind = KIND_SUMMARY;
               if (err_ff != ERR_NONE) begin
                  push_op.err = err_ff;
               end else if (group_left_ff != 8'd0) begin
                  push_op.err = ERR_TRUNCATED;
               end else if (dec_count_ff < DEC_W'(HDR_LEN)) begin
                  push_op.err = ERR_SHORT;
               end
            end
            group_left_in   = 8'd0;
            zero_pending_in = 1'b0;
            long_group_in   = 1'b0;
            wire_count_in   = '0;
            dec_count_in    = '0;
            err_in          = ERR_NONE;
         end else begin
            if (wire_count_ff < WIRE_W'(MAX_WIRE)) begin
               wire_count_in = wire_count_ff + WIRE_W'(1);
            end
            if (err_ff != ERR_NONE) begin
               // Rest of an errored frame is swallowed.
            end else if (wire_count_in > WIRE_W'(MAX_WIRE - 1)) begin
               err_in = ERR_WIRE_LONG;
            end else if (group_left_ff == 8'd0) begin
               // Code byte: release the held zero and open a new group.
               append_req      = zero_pending_ff;
               append_val      = 8'd0;
               long_group_in   = (req_wire_byte == CODE_LONG_GROUP);
               group_left_in   = req_wire_byte - 8'd1;
               zero_pending_in = (req_wire_byte == 8'd1);
            end else begin
               // Literal byte inside a group.
               group_left_in = group_left_ff - 8'd1;
               if (group_left_ff == 8'd1) begin
                  zero_pending_in = !long_group_ff;
               end
               append_req = 1'b1;
               append_val = req_wire_byte;
            end

            // Append one decoded byte unless the frame is already too long.
            if (append_req) begin
               if (dec_count_ff >= DEC_W'(HDR_LEN + MAX_PAYLOAD)) begin
                  err_in = ERR_DECODED_LONG;
               end else begin
                  push_valid   = 1'b1;
                  push_op.data = append_val;
                  dec_count_in = dec_count_ff + DEC_W'(1);
               end
            end
         end
      end
   end

   // Frame decode state.
   always_ff @(posedge clock) begin
      if (reset) begin
         group_left_ff   <= 8'd0;
         zero_pending_ff <= 1'b0;
         long_group_ff   <= 1'b0;
         wire_count_ff   <= '0;
         dec_count_ff    <= '0;
         err_ff          <= ERR_NONE;
      end else begin
         group_left_ff   <= group_left_in;
         zero_pending_ff <= zero_pending_in;
         long_group_ff   <= long_group_in;
         wire_count_ff   <= wire_count_in;
         dec_count_ff    <= dec_count_in;
         err_ff          <= err_in;
      end
   end

endmodule

@@ src/cfd_fifo.sv @@
// Short queue of operations between the decode front and the frame back.
module cfd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  cfd_pkg::op_type  push_op,
   output logic             full,
   output logic             head_valid,
   output cfd_pkg::op_type  head_op,
   input  logic             pop
);
   import cfd_pkg::*;

   op_type             mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full       = (count_ff == (FIFO_AW + 1)'(FIFO_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_op    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + FIFO_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + FIFO_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (FIFO_AW + 1)'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - (FIFO_AW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

@@ src/cfd_back.sv @@
// Frame back: collects the header, emits payload beats and checks the header at frame end.
module cfd_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         head_valid,
   input  cfd_pkg::op_type              head_op,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_item_kind,
   output logic [7:0]                   rsp_payload_byte,
   output logic [cfd_pkg::IDX_W-1:0]    rsp_payload_index,
   output logic [7:0]                   rsp_operation_code,
   output logic [7:0]                   rsp_status_code,
   output logic [cfd_pkg::LEN_W-1:0]    rsp_payload_length,
   output logic [31:0]                  rsp_frame_id,
   output logic [31:0]                  rsp_session_id,
   output logic                         rsp_frame_ok,
   output logic [2:0]                   rsp_error_code
);
   import cfd_pkg::*;

   logic [7:0]       header_ff [HDR_LEN];
   logic             valid_ff, valid_in;
   kind_type         kind_ff, kind_in;
   logic [7:0]       byte_ff, byte_in;
   logic [IDX_W-1:0] index_ff, index_in;
   logic [7:0]       op_code_ff, op_code_in;
   logic [7:0]       status_ff, status_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic [31:0]      frame_id_ff, frame_id_in;
   logic [31:0]      session_ff, session_in;
   logic             ok_ff, ok_in;
   err_type          err_ff, err_in;
   logic [LEN_W-1:0] hdr_len;
   logic             magic_ok;
   logic             in_header;
   logic             emits;
   err_type          final_err;

   // Take the next operation when the output register is free or drains now.
   assign pop       = head_valid && (!valid_ff || !rsp_stall);
   assign in_header = (head_op.kind == KIND_PAYLOAD) && (head_op.count < DEC_W'(HDR_LEN));
   assign emits     = !in_header;

   assign hdr_len  = {header_ff[7], header_ff[6]};
   assign magic_ok = (header_ff[0] == MAGIC_0) && (header_ff[1] == MAGIC_1) &&
                     (header_ff[2] == MAGIC_2) && (header_ff[3] == MAGIC_3);

   // Header checks at frame end, first failing check wins.
   always_comb begin
      final_err = head_op.err;
      if (head_op.err == ERR_NONE) begin
         if (!magic_ok) begin
            final_err = ERR_MAGIC;
         end else if ({1'b0, hdr_len} > (LEN_W + 1)'(MAX_PAYLOAD)) begin
            final_err = ERR_SIZE;
         end else if ((LEN_W + 1)'(head_op.count) !=
                      ({1'b0, hdr_len} + (LEN_W + 1)'(HDR_LEN))) begin
            final_err = ERR_MISMATCH;
         end
      end
   end

   // Next contents of the output register.
   always_comb begin
      valid_in    = pop ? emits : (valid_ff && rsp_stall);
      kind_in     = kind_ff;
      byte_in     = byte_ff;
      index_in    = index_ff;
      op_code_in  = op_code_ff;
      status_in   = status_ff;
      length_in   = length_ff;
      frame_id_in = frame_id_ff;
      session_in  = session_ff;
      ok_in       = ok_ff;
      err_in      = err_ff;
      if (pop && emits) begin
         kind_in = head_op.kind;
         if (head_op.kind == KIND_SUMMARY) begin
            byte_in     = 8'd0;
            index_in    = '0;
            op_code_in  = header_ff[4];
            status_in   = header_ff[5];
            length_in   = hdr_len;
            frame_id_in = {header_ff[11], header_ff[10], header_ff[9], header_ff[8]};
            session_in  = {header_ff[15], header_ff[14], header_ff[13], header_ff[12]};
            ok_in       = (final_err == ERR_NONE);
            err_in      = final_err;
         end else begin
            byte_in     = head_op.data;
            index_in    = IDX_W'(head_op.count - DEC_W'(HDR_LEN));
            op_code_in  = 8'd0;
            status_in   = 8'd0;
            length_in   = '0;
            frame_id_in = 32'd0;
            session_in  = 32'd0;
            ok_in       = 1'b0;
            err_in      = ERR_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Output payload and header bytes; the header is cleared once its summary is taken.
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      byte_ff     <= byte_in;
      index_ff    <= index_in;
      op_code_ff  <= op_code_in;
      status_ff   <= status_in;
      length_ff   <= length_in;
      frame_id_ff <= frame_id_in;
      session_ff  <= session_in;
      ok_ff       <= ok_in;
      err_ff      <= err_in;
      if (pop && in_header) begin
         header_ff[head_op.count[HDR_AW-1:0]] <= head_op.data;
      end else if (pop && (head_op.kind == KIND_SUMMARY)) begin
         for (int i = 0; i < HDR_LEN; i++) begin
            header_ff[i] <= 8'd0;
         end
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_item_kind      = (kind_ff == KIND_SUMMARY);
   assign rsp_payload_byte   = byte_ff;
   assign rsp_payload_index  = index_ff;
   assign rsp_operation_code = op_code_ff;
   assign rsp_status_code    = status_ff;
   assign rsp_payload_length = length_ff;
   assign rsp_frame_id       = frame_id_ff;
   assign rsp_session_id     = session_ff;
   assign rsp_frame_ok       = ok_ff;
   assign rsp_error_code     = err_ff;

endmodule

@@ src/cobs_frame_decoder.sv @@
// Top level of the COBS frame decoder: decode front, operation queue and frame back.
// Path: an accepted beat is written into the queue, then popped into the output register behind rsp_valid.
// Throughput: one wire byte per cycle while req_stall is low; the four-entry queue and the output register
// let each side stall on its own, and req_stall rises only when the queue is full.
// Reset: synchronous and active high; it clears the group counter, counts, error latch,
// queue and output valid. Header bytes not received in a frame read as zero after a summary.
module cobs_frame_decoder (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [7:0]                   req_wire_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_item_kind,
   output logic [7:0]                   rsp_payload_byte,
   output logic [cfd_pkg::IDX_W-1:0]    rsp_payload_index,
   output logic [7:0]                   rsp_operation_code,
   output logic [7:0]                   rsp_status_code,
   output logic [cfd_pkg::LEN_W-1:0]    rsp_payload_length,
   output logic [31:0]                  rsp_frame_id,
   output logic [31:0]                  rsp_session_id,
   output logic                         rsp_frame_ok,
   output logic [2:0]                   rsp_error_code
);
   import cfd_pkg::*;

   logic   fifo_full;
   logic   push_valid;
   op_type push_op;
   logic   head_valid;
   op_type head_op;
   logic   pop;

   // Byte decode and frame bookkeeping.
   cfd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_wire_byte (req_wire_byte),
      .req_stall     (req_stall),
      .fifo_full     (fifo_full),
      .push_valid    (push_valid),
      .push_op       (push_op)
   );

   // Decoupling queue.
   cfd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_op    (push_op),
      .full       (fifo_full),
      .head_valid (head_valid),
      .head_op    (head_op),
      .pop        (pop)
   );

   // Header collection, checks and result register.
   cfd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_op            (head_op),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_item_kind      (rsp_item_kind),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_payload_index  (rsp_payload_index),
      .rsp_operation_code (rsp_operation_code),
      .rsp_status_code    (rsp_status_code),
      .rsp_payload_length (rsp_payload_length),
      .rsp_frame_id       (rsp_frame_id),
      .rsp_session_id     (rsp_session_id),
      .rsp_frame_ok       (rsp_frame_ok),
      .rsp_error_code     (rsp_error_code)
   );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the COBS frame decoder: stuffed frames, predictor and checker.
`timescale 1ns / 100ps

module tb_top;
   import cfd_pkg::*;

   // Stimulus pacing and run limits.
   localparam int          RANDOM_BYTES  = 550;
   localparam int          PACE_SPAN     = 256;
   localparam int          HOLD_CYCLES   = 300;
   localparam int          HOLD_SPACING  = 1000;
   localparam int          IDLE_LIMIT    = 2000;
   localparam int          DRAIN_CYCLES  = 20;
   localparam int          REPORT_CAP    = 100;
   localparam logic [7:0]  FRAME_DELIM   = 8'h00;
   localparam logic [31:0] ALL_LANES     = 32'hffff_ffff;

   typedef enum logic [1:0] {
      PACE_QUIET,
      PACE_SEND_GAPS,
      PACE_RECV_STALLS,
      PACE_BOTH
   } pace_type;

   // One expected output beat; hdr_mask marks header bytes whose value is known.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic [9:0]  index;
      logic [7:0]  op;
      logic [7:0]  status;
      logic [15:0] len;
      logic [31:0] fid;
      logic [31:0] sid;
      logic        ok;
      err_type     err;
      logic [15:0] hdr_mask;
   } decoded_beat_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [7:0]           req_wire_byte = 8'h00;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_item_kind;
   logic [7:0]           rsp_payload_byte;
   logic [IDX_W-1:0]     rsp_payload_index;
   logic [7:0]           rsp_operation_code;
   logic [7:0]           rsp_status_code;
   logic [LEN_W-1:0]     rsp_payload_length;
   logic [31:0]          rsp_frame_id;
   logic [31:0]          rsp_session_id;
   logic                 rsp_frame_ok;
   logic [2:0]           rsp_error_code;

   // Stimulus and expectation stores.
   logic [7:0]           wire_q[$];
   logic [7:0]           frame_body[$];
   logic [7:0]           group_run[$];
   decoded_beat_type     beats_due[$];

   int                   sent_cnt = 0;
   int                   mismatches = 0;
   int                   hold_left = 0;
   int                   next_hold_at = 64;

   // Decoder state as predicted from the accepted wire bytes.
   logic [7:0]           grp_left;
   logic                 zero_held;
   logic                 ff_group;
   int unsigned          wire_seen;
   int unsigned          dec_seen;
   logic [7:0]           hdr_bytes[16];
   logic [15:0]          hdr_valid;
   err_type              err_latched;

   cobs_frame_decoder dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_wire_byte      (req_wire_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_item_kind      (rsp_item_kind),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_payload_index  (rsp_payload_index),
      .rsp_operation_code (rsp_operation_code),
      .rsp_status_code    (rsp_status_code),
      .rsp_payload_length (rsp_payload_length),
      .rsp_frame_id       (rsp_frame_id),
      .rsp_session_id     (rsp_session_id),
      .rsp_frame_ok       (rsp_frame_ok),
      .rsp_error_code     (rsp_error_code)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor: frame state after a delimiter or reset.
   task automatic clear_frame_state();
      grp_left    = 8'h00;
      zero_held   = 1'b0;
      ff_group    = 1'b0;
      wire_seen   = 0;
      dec_seen    = 0;
      err_latched = ERR_NONE;
      hdr_valid   = 16'h0000;
      foreach (hdr_bytes[i]) hdr_bytes[i] = 8'h00;
   endtask

   // Predictor: one decoded byte goes to the header, out as payload, or overflows.
   task automatic append_decoded(input logic [7:0] v);
      decoded_beat_type beat;
      if (dec_seen >= HDR_LEN + MAX_PAYLOAD) begin
         err_latched = ERR_DECODED_LONG;
      end else if (dec_seen < HDR_LEN) begin
         hdr_bytes[dec_seen[3:0]] = v;
         hdr_valid[dec_seen[3:0]] = 1'b1;
         dec_seen++;
      end else begin
         beat          = '0;
         beat.kind     = KIND_PAYLOAD;
         beat.data     = v;
         beat.index    = 10'(dec_seen - HDR_LEN);
         beat.err      = ERR_NONE;
         beat.hdr_mask = 16'hffff;
         beats_due.push_back(beat);
         dec_seen++;
      end
   endtask

   // Predictor: consume one accepted wire byte.
   task automatic decode_wire_byte(input logic [7:0] b);
      decoded_beat_type beat;
      err_type          e;
      logic [15:0]      plen;
      if (b == FRAME_DELIM) begin
         // Back-to-back delimiters close nothing.
         if (wire_seen != 0 || err_latched != ERR_NONE) begin
            e    = err_latched;
            plen = {hdr_bytes[7], hdr_bytes[6]};
            if (e == ERR_NONE && grp_left != 0)
               e = ERR_TRUNCATED;
            if (e == ERR_NONE && dec_seen < HDR_LEN)
               e = ERR_SHORT;
            if (e == ERR_NONE && (hdr_bytes[0] != MAGIC_0 || hdr_bytes[1] != MAGIC_1 ||
                                  hdr_bytes[2] != MAGIC_2 || hdr_bytes[3] != MAGIC_3))
               e = ERR_MAGIC;
            if (e == ERR_NONE && plen > MAX_PAYLOAD)
               e = ERR_SIZE;
            if (e == ERR_NONE && dec_seen != HDR_LEN + plen)
               e = ERR_MISMATCH;
            beat          = '0;
            beat.kind     = KIND_SUMMARY;
            beat.op       = hdr_bytes[4];
            beat.status   = hdr_bytes[5];
            beat.len      = plen;
            beat.fid      = {hdr_bytes[11], hdr_bytes[10], hdr_bytes[9], hdr_bytes[8]};
            beat.sid      = {hdr_bytes[15], hdr_bytes[14], hdr_bytes[13], hdr_bytes[12]};
            beat.ok       = (e == ERR_NONE);
            beat.err      = e;
            beat.hdr_mask = hdr_valid;
            beats_due.push_back(beat);
            clear_frame_state();
            // The header reads as zero from here on until it is written again.
            hdr_valid = 16'hffff;
         end
      end else begin
         if (wire_seen < MAX_WIRE)
            wire_seen++;
         // Once an error is latched the rest of the frame is swallowed.
         if (err_latched == ERR_NONE) begin
            if (wire_seen > MAX_WIRE - 1) begin
               err_latched = ERR_WIRE_LONG;
            end else if (grp_left == 0) begin
               // Code byte: release the implied zero of the previous group first.
               if (zero_held) begin
                  zero_held = 1'b0;
                  append_decoded(8'h00);
               end
               ff_group = (b == CODE_LONG_GROUP);
               grp_left = b - 8'd1;
               if (grp_left == 0)
                  zero_held = !ff_group;
            end else begin
               grp_left = grp_left - 8'd1;
               if (grp_left == 0)
                  zero_held = !ff_group;
               append_decoded(b);
            end
         end
      end
   endtask

   // Stimulus: COBS stuffing of frame_body onto the wire queue, delimiter not included.
   task automatic emit_group(input logic [7:0] code);
      wire_q.push_back(code);
      foreach (group_run[i]) wire_q.push_back(group_run[i]);
      group_run.delete();
   endtask

   task automatic stuff_frame_body();
      group_run.delete();
      foreach (frame_body[i]) begin
         if (frame_body[i] == FRAME_DELIM) begin
            emit_group(8'(group_run.size() + 1));
         end else begin
            group_run.push_back(frame_body[i]);
            if (group_run.size() == 254)
               emit_group(CODE_LONG_GROUP);
         end
      end
      emit_group(8'(group_run.size() + 1));
   endtask

   task automatic send_frame();
      stuff_frame_body();
      wire_q.push_back(FRAME_DELIM);
   endtask

   // Stimulus: a fresh frame body holding a header with correct magic.
   task automatic start_frame(input logic [7:0] op, input logic [7:0] st,
                              input logic [15:0] len, input logic [31:0] fid,
                              input logic [31:0] sid);
      int i;
      frame_body.delete();
      frame_body.push_back(MAGIC_0);
      frame_body.push_back(MAGIC_1);
      frame_body.push_back(MAGIC_2);
      frame_body.push_back(MAGIC_3);
      frame_body.push_back(op);
      frame_body.push_back(st);
      frame_body.push_back(len[7:0]);
      frame_body.push_back(len[15:8]);
      for (i = 0; i < 4; i++) frame_body.push_back(fid[8*i +: 8]);
      for (i = 0; i < 4; i++) frame_body.push_back(sid[8*i +: 8]);
   endtask

   // Payload bytes lean toward zero and 0xff so group boundaries vary.
   function automatic logic [7:0] body_byte();
      int r;
      r = $urandom_range(99);
      if (r < 20) return 8'h00;
      if (r < 30) return 8'hff;
      if (r < 35) return 8'h01;
      return 8'($urandom_range(255));
   endfunction

   task automatic add_payload(input int n, input bit dense);
      int i;
      for (i = 0; i < n; i++)
         frame_body.push_back(dense ? 8'($urandom_range(255, 1)) : body_byte());
   endtask

   task automatic start_random_frame(input logic [15:0] len);
      start_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len,
                  $urandom(), $urandom());
   endtask

   // Idle pattern rotates every PACE_SPAN accepted wire bytes.
   function automatic pace_type current_pace();
      return pace_type'((sent_cnt / PACE_SPAN) % 4);
   endfunction

   function automatic logic sender_gap();
      pace_type p;
      p = current_pace();
      if (p == PACE_SEND_GAPS) return $urandom_range(99) < 52;
      if (p == PACE_BOTH) return $urandom_range(99) < 14;
      return 1'b0;
   endfunction

   function automatic logic receiver_gap();
      pace_type p;
      p = current_pace();
      if (p == PACE_RECV_STALLS) return $urandom_range(99) < 52;
      if (p == PACE_BOTH) return $urandom_range(99) < 14;
      return 1'b0;
   endfunction

   // Request driver: predicts each accepted beat, then offers the next wire byte.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_wire_byte(req_wire_byte);
            sent_cnt <= sent_cnt + 1;
         end
         if (!req_valid || !req_stall) begin
            if (wire_q.size() != 0 && !sender_gap()) begin
               req_valid     <= 1'b1;
               req_wire_byte <= wire_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response back-pressure, with a periodic long hold-off to fill the decoder.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!reset && sent_cnt >= next_hold_at) begin
         rsp_stall    <= 1'b1;
         hold_left    <= HOLD_CYCLES;
         next_hold_at <= next_hold_at + HOLD_SPACING;
      end else begin
         rsp_stall <= receiver_gap();
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < REPORT_CAP)
         $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want, input logic [31:0] mask);
      if ((got & mask) !== (want & mask))
         report_mismatch(what, got, want);
   endtask

   // Byte lanes of a header field whose value is known.
   function automatic logic [31:0] lane_mask(input logic [15:0] m, input int first,
                                             input int n);
      logic [31:0] lanes;
      int          i;
      lanes = '0;
      for (i = 0; i < n; i++)
         if (m[first + i]) lanes[8*i +: 8] = 8'hff;
      return lanes;
   endfunction

   // Response monitor: each accepted beat against the oldest expectation.
   always @(posedge clock) begin : check_rsp
      decoded_beat_type want;
      logic [15:0]      m;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (beats_due.size() == 0) begin
            report_mismatch("beat with nothing expected", 32'(rsp_item_kind), 32'd0);
         end else begin
            want = beats_due.pop_front();
            m    = want.hdr_mask;
            check_field("item_kind", 32'(rsp_item_kind), 32'(want.kind), ALL_LANES);
            check_field("payload_byte", 32'(rsp_payload_byte), 32'(want.data), ALL_LANES);
            check_field("payload_index", 32'(rsp_payload_index), 32'(want.index),
                        ALL_LANES);
            check_field("operation_code", 32'(rsp_operation_code), 32'(want.op),
                        lane_mask(m, 4, 1));
            check_field("status_code", 32'(rsp_status_code), 32'(want.status),
                        lane_mask(m, 5, 1));
            check_field("payload_length", 32'(rsp_payload_length), 32'(want.len),
                        lane_mask(m, 6, 2));
            check_field("frame_id", rsp_frame_id, want.fid, lane_mask(m, 8, 4));
            check_field("session_id", rsp_session_id, want.sid, lane_mask(m, 12, 4));
            check_field("frame_ok", 32'(rsp_frame_ok), 32'(want.ok), ALL_LANES);
            check_field("error_code", 32'(rsp_error_code), 32'(want.err), ALL_LANES);
         end
      end
   end

   // Stimulus build, reset, completion wait and verdict.
   initial begin
      int          n;
      int          r;
      int          c;
      int          k;
      int          stop_at;
      int          total;
      int          idle;
      logic [15:0] len;

      clear_frame_state();

      // Directed: a good frame of zeros writes every header byte first.
      start_frame(8'h00, 8'h00, 16'h0000, 32'h0, 32'h0);
      send_frame();
      // Repeated delimiters.
      wire_q.push_back(FRAME_DELIM);
      wire_q.push_back(FRAME_DELIM);
      // All-ones header with a short payload holding zero and 0xff.
      start_frame(8'hff, 8'hff, 16'd3, 32'hffff_ffff, 32'hffff_ffff);
      frame_body.push_back(8'h00);
      frame_body.push_back(8'hff);
      frame_body.push_back(8'h7f);
      send_frame();
      // Short frames: five decoded bytes, then a lone code byte.
      frame_body = '{MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3, 8'h07};
      send_frame();
      frame_body.delete();
      send_frame();
      // Delimiter inside an open group.
      start_frame(8'h12, 8'h34, 16'd0, 32'h0102_0304, 32'h0506_0708);
      stuff_frame_body();
      wire_q.push_back(8'h05);
      wire_q.push_back(8'h11);
      wire_q.push_back(8'h22);
      wire_q.push_back(FRAME_DELIM);
      // Wrong magic, declared size too large, length mismatch.
      start_frame(8'h01, 8'h02, 16'd0, 32'h11, 32'h22);
      frame_body[0] = 8'h4f;
      send_frame();
      start_frame(8'h03, 8'h04, 16'hffff, 32'h33, 32'h44);
      send_frame();
      start_frame(8'h05, 8'h06, 16'd2, 32'h55, 32'h66);
      frame_body.push_back(8'h99);
      send_frame();

      // One oversized frame: decoded bytes run past the payload limit, indexes reach the top.
      start_frame(8'h5a, 8'ha5, 16'd1024, $urandom(), $urandom());
      add_payload(MAX_PAYLOAD + 2, 1'b1);
      send_frame();

      // Random part: mostly well-formed frames, the rest broken frames and noise.
      stop_at = wire_q.size() + RANDOM_BYTES;
      while (wire_q.size() < stop_at) begin
         r = $urandom_range(99);
         n = ($urandom_range(99) < 4) ? $urandom_range(300, 254) : $urandom_range(24);
         if (r < 55) begin
            start_random_frame(16'(n));
            add_payload(n, n > 200);
            send_frame();
         end else if (r < 63) begin
            len = 16'($urandom_range(1) ? n + $urandom_range(4, 1)
                                        : $urandom_range(MAX_PAYLOAD));
            start_random_frame(len);
            add_payload(n % 25, 1'b0);
            send_frame();
         end else if (r < 68) begin
            start_random_frame(16'($urandom_range(65535, MAX_PAYLOAD + 1)));
            add_payload(n % 25, 1'b0);
            send_frame();
         end else if (r < 73) begin
            start_random_frame(16'(n % 25));
            add_payload(n % 25, 1'b0);
            k = $urandom_range(3);
            frame_body[k] = frame_body[k] ^ 8'($urandom_range(255, 1));
            send_frame();
         end else if (r < 79) begin
            frame_body.delete();
            add_payload($urandom_range(HDR_LEN - 1), 1'b0);
            send_frame();
         end else if (r < 85) begin
            start_random_frame(16'(n % 25));
            add_payload(n % 25, 1'b0);
            stuff_frame_body();
            c = $urandom_range(30, 2);
            k = $urandom_range(c - 2);
            wire_q.push_back(8'(c));
            repeat (k) wire_q.push_back(8'($urandom_range(255, 1)));
            wire_q.push_back(FRAME_DELIM);
         end else if (r < 93) begin
            repeat ($urandom_range(40, 1))
               wire_q.push_back(($urandom_range(99) < 30) ? FRAME_DELIM
                                                           : 8'($urandom_range(255)));
         end else begin
            repeat ($urandom_range(3, 1)) wire_q.push_back(FRAME_DELIM);
         end
      end
      wire_q.push_back(FRAME_DELIM);
      total = wire_q.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Wait for every byte to be taken and every beat to arrive, with a stall watchdog.
      idle = 0;
      while (!(sent_cnt == total && beats_due.size() == 0) && idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle = 0;
         else
            idle++;
      end

      if (idle >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
      end else begin
         repeat (DRAIN_CYCLES) @(posedge clock);
         if (mismatches == 0 && beats_due.size() == 0)
            $display("RESULT: OK");
         else
            $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
